FILE: rtl/zssd_pkg.sv
// Shared widths and constants for the zero-mean SSD block matcher.
package zssd_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int COORD_BITS  = 12;
    localparam int WIN_BITS    = 9;
    localparam int DIFF_BITS   = SAMPLE_BITS + 10;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS + 9;
    localparam int PROD_BITS   = 2 * DIFF_BITS;
    localparam int COST_BITS   = 24;
    localparam int CNT_BITS    = $clog2(PROD_BITS);

    localparam logic [WIN_BITS-1:0]  WIN_RESET = WIN_BITS'(25);
    localparam logic [COST_BITS-1:0] COST_MAX  = {COST_BITS{1'b1}};

endpackage

FILE: rtl/zssd_if.sv
// Valid/ready channels for sample pairs and match results.
interface zssd_in_if;
    logic                               valid;
    logic                               ready;
    logic [zssd_pkg::SAMPLE_BITS-1:0]   ref_sample;
    logic [zssd_pkg::SAMPLE_BITS-1:0]   cand_sample;
    logic signed [zssd_pkg::COORD_BITS-1:0] cand_dx;
    logic signed [zssd_pkg::COORD_BITS-1:0] cand_dy;
    logic                               window_end;
    logic                               search_end;

    modport source (output valid, ref_sample, cand_sample, cand_dx, cand_dy,
                    window_end, search_end, input ready);
    modport sink (input valid, ref_sample, cand_sample, cand_dx, cand_dy,
                  window_end, search_end, output ready);
endinterface

interface zssd_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [zssd_pkg::COORD_BITS-1:0] best_dx;
    logic signed [zssd_pkg::COORD_BITS-1:0] best_dy;
    logic [zssd_pkg::COST_BITS-1:0]         min_cost;
    logic                                   found;

    modport source (output valid, best_dx, best_dy, min_cost, found, input ready);
    modport sink (input valid, best_dx, best_dy, min_cost, found, output ready);
endinterface

FILE: rtl/zssd_block_match_argmin_top.sv
// Zero-mean SSD block matcher: one sample pair per accepted item, arg-min over
// candidates. A sample with neither window_end nor search_end only accumulates. A
// sample with window_end passes through: accumulate, square the difference
// sum in ST_MUL, run the one-bit-per-cycle restoring divider that removes
// the mean (diff_sum^2 / window_samples) in ST_DIV, then form the cost and update
// the minimum in ST_UPD. A sample with search_end also loads the result register,
// waiting while a previous result has not been taken. The ready line is low
// whenever the sequencer is not idle. window_samples of 0 divides as 1.
module zssd_block_match_argmin_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [zssd_pkg::WIN_BITS-1:0]   cfg_wr_data,
    zssd_in_if.sink                         samples,
    zssd_out_if.source                      results
);
    import zssd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]                 state_reg, state_next;
    logic [WIN_BITS-1:0]        win_reg, win_next;
    logic [DIFF_BITS-1:0]       diff_sum_reg, diff_sum_next;
    logic [SQ_BITS-1:0]         sq_sum_reg, sq_sum_next;
    logic [COST_BITS-1:0]       low_cost_reg, low_cost_next;
    logic [COORD_BITS-1:0]      low_dx_reg, low_dx_next;
    logic [COORD_BITS-1:0]      low_dy_reg, low_dy_next;
    logic                       have_low_reg, have_low_next;
    logic [COORD_BITS-1:0]      tag_dx_reg, tag_dx_next;
    logic [COORD_BITS-1:0]      tag_dy_reg, tag_dy_next;
    logic                       send_reg, send_next;
    logic [PROD_BITS-1:0]       quo_reg, quo_next;
    logic [WIN_BITS-1:0]        rem_reg, rem_next;
    logic [CNT_BITS-1:0]        cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0]      out_dx_reg, out_dx_next;
    logic [COORD_BITS-1:0]      out_dy_reg, out_dy_next;
    logic [COST_BITS-1:0]       out_cost_reg, out_cost_next;
    logic                       out_found_reg, out_found_next;

    // per-sample difference terms
    logic [SAMPLE_BITS:0]       d_tc;
    logic [SAMPLE_BITS-1:0]     d_mag;
    logic [2*SAMPLE_BITS-1:0]   d_sq;
    // window-end arithmetic
    logic [DIFF_BITS-1:0]       sum_mag;
    logic [WIN_BITS-1:0]        div_n;
    logic [WIN_BITS:0]          rem_sh;
    logic                       rem_ge;
    logic [PROD_BITS-1:0]       sq_ext;
    logic [PROD_BITS-1:0]       cost_wide;
    logic [COST_BITS-1:0]       cost;
    logic                       out_free;

    assign samples.ready    = (state_reg == ST_IDLE);
    assign results.valid    = out_valid_reg;
    assign results.best_dx  = out_dx_reg;
    assign results.best_dy  = out_dy_reg;
    assign results.min_cost = out_cost_reg;
    assign results.found    = out_found_reg;

    // difference of the incoming pair
    assign d_tc  = {1'b0, samples.ref_sample} - {1'b0, samples.cand_sample};
    assign d_mag = (samples.ref_sample >= samples.cand_sample)
                 ? samples.ref_sample - samples.cand_sample
                 : samples.cand_sample - samples.ref_sample;
    assign d_sq  = d_mag * d_mag;

    // magnitude of the difference sum and the divisor
    assign sum_mag = diff_sum_reg[DIFF_BITS-1] ? (~diff_sum_reg + 1'b1) : diff_sum_reg;
    assign div_n   = (win_reg == '0) ? WIN_BITS'(1) : win_reg;

    // restoring divider step
    assign rem_sh = {rem_reg, quo_reg[PROD_BITS-1]};
    assign rem_ge = (rem_sh >= {1'b0, div_n});

    // cost = square sum - quotient, clamped at zero and saturated
    assign sq_ext    = {{(PROD_BITS-SQ_BITS){1'b0}}, sq_sum_reg};
    assign cost_wide = sq_ext - quo_reg;
    always_comb
    begin
        if (sq_ext <= quo_reg)
        begin
            cost = '0;
        end
        else if (cost_wide[PROD_BITS-1:COST_BITS] != '0)
        begin
            cost = COST_MAX;
        end
        else
        begin
            cost = cost_wide[COST_BITS-1:0];
        end
    end

    assign out_free = !out_valid_reg || results.ready;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        win_next       = cfg_wr_en ? cfg_wr_data : win_reg;
        diff_sum_next  = diff_sum_reg;
        sq_sum_next    = sq_sum_reg;
        low_cost_next  = low_cost_reg;
        low_dx_next    = low_dx_reg;
        low_dy_next    = low_dy_reg;
        have_low_next  = have_low_reg;
        tag_dx_next    = tag_dx_reg;
        tag_dy_next    = tag_dy_reg;
        send_next      = send_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_dx_next    = out_dx_reg;
        out_dy_next    = out_dy_reg;
        out_cost_next  = out_cost_reg;
        out_found_next = out_found_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                begin
                    diff_sum_next = diff_sum_reg
                        + {{(DIFF_BITS-SAMPLE_BITS-1){d_tc[SAMPLE_BITS]}}, d_tc};
                    sq_sum_next   = sq_sum_reg + {{(SQ_BITS-2*SAMPLE_BITS){1'b0}}, d_sq};
                    tag_dx_next   = samples.cand_dx;
                    tag_dy_next   = samples.cand_dy;
                    send_next     = samples.search_end;
                    if (samples.window_end)
                    begin
                        state_next = ST_MUL;
                    end
                    else if (samples.search_end)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_MUL:
            begin
                quo_next   = sum_mag * sum_mag;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = rem_ge ? WIN_BITS'(rem_sh - {1'b0, div_n}) : rem_sh[WIN_BITS-1:0];
                quo_next = {quo_reg[PROD_BITS-2:0], rem_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(PROD_BITS - 1))
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                // strict compare keeps the earliest candidate on ties
                if (!have_low_reg || cost < low_cost_reg)
                begin
                    low_cost_next = cost;
                    low_dx_next   = tag_dx_reg;
                    low_dy_next   = tag_dy_reg;
                    have_low_next = 1'b1;
                end
                diff_sum_next = '0;
                sq_sum_next   = '0;
                state_next    = send_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_dx_next    = have_low_reg ? low_dx_reg : '0;
                    out_dy_next    = have_low_reg ? low_dy_reg : '0;
                    out_cost_next  = have_low_reg ? low_cost_reg : COST_MAX;
                    out_found_next = have_low_reg;
                    diff_sum_next  = '0;
                    sq_sum_next    = '0;
                    low_cost_next  = '0;
                    low_dx_next    = '0;
                    low_dy_next    = '0;
                    have_low_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and search state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_reg       <= WIN_RESET;
            diff_sum_reg  <= '0;
            sq_sum_reg    <= '0;
            low_cost_reg  <= '0;
            low_dx_reg    <= '0;
            low_dy_reg    <= '0;
            have_low_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            diff_sum_reg  <= diff_sum_next;
            sq_sum_reg    <= sq_sum_next;
            low_cost_reg  <= low_cost_next;
            low_dx_reg    <= low_dx_next;
            low_dy_reg    <= low_dy_next;
            have_low_reg  <= have_low_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        tag_dx_reg    <= tag_dx_next;
        tag_dy_reg    <= tag_dy_next;
        send_reg      <= send_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        out_dx_reg    <= out_dx_next;
        out_dy_reg    <= out_dy_next;
        out_cost_reg  <= out_cost_next;
        out_found_reg <= out_found_next;
    end

endmodule

FILE: rtl/zssd_checker.sv
// Port-level checks for the block matcher, bound to the top level.
module zssd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             in_window_end,
    input logic                             in_search_end,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [zssd_pkg::COORD_BITS-1:0]  out_best_dx,
    input logic [zssd_pkg::COORD_BITS-1:0]  out_best_dy,
    input logic [zssd_pkg::COST_BITS-1:0]   out_min_cost,
    input logic                             out_found
);
    import zssd_pkg::*;

    // a window end keeps the block busy while the divider runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_window_end) |=> !in_ready)
        else $error("ready high right after a window end");

    // after a plain sample, ready is high again in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !in_window_end && !in_search_end) |=> in_ready)
        else $error("ready dropped after a plain sample");

    // an empty search reports infinite cost and zero displacement
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_found) |->
        (out_min_cost == COST_MAX && out_best_dx == '0 && out_best_dy == '0))
        else $error("empty search result malformed");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_min_cost)))
        else $error("stalled result changed");

endmodule

bind zssd_block_match_argmin_top zssd_checker u_zssd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (samples.valid),
    .in_ready      (samples.ready),
    .in_window_end (samples.window_end),
    .in_search_end (samples.search_end),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .out_best_dx   (results.best_dx),
    .out_best_dy   (results.best_dy),
    .out_min_cost  (results.min_cost),
    .out_found     (results.found)
);

FILE: test/zssd_block_match_argmin_top_tb.sv
// Self-checking testbench for the zero-mean SSD block matcher with arg-min selection.
`timescale 1ns / 1ps

module zssd_block_match_argmin_top_tb;
    import zssd_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 60;     // divider latency plus result load, with margin
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 3000;
    localparam int RANDOM_ITEMS  = 60;
    localparam int RANDOM_SEARCHES = 8;

    typedef struct {
        logic [SAMPLE_BITS-1:0]        ref_sample;
        logic [SAMPLE_BITS-1:0]        cand_sample;
        logic signed [COORD_BITS-1:0]  dx;
        logic signed [COORD_BITS-1:0]  dy;
        logic                          window_end;
        logic                          search_end;
    } sample_pair_t;

    typedef struct {
        logic signed [COORD_BITS-1:0]  best_dx;
        logic signed [COORD_BITS-1:0]  best_dy;
        logic [COST_BITS-1:0]          min_cost;
        logic                          found;
    } match_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en;
    logic [WIN_BITS-1:0] cfg_wr_data;

    zssd_in_if  samples_bus ();
    zssd_out_if results_bus ();

    zssd_block_match_argmin_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .samples     (samples_bus),
        .results     (results_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Stimulus and expectations
    sample_pair_t pending_pairs[$];
    match_t       expected_matches[$];
    sample_pair_t on_bus;
    int           queued_items;
    int           queued_searches;
    int           error_count;

    // Idle control shared with the drivers
    bit idle_enable;
    bit hold_req;

    // Matcher state mirror
    logic [WIN_BITS-1:0]          window_len;
    logic [DIFF_BITS-1:0]         diff_acc;
    logic [SQ_BITS-1:0]           square_acc;
    logic [SQ_BITS-1:0]           lowest_cost;
    logic signed [COORD_BITS-1:0] lowest_dx;
    logic signed [COORD_BITS-1:0] lowest_dy;
    bit                           have_lowest;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("%0t: mismatch in %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    endtask

    // Accumulate one pair, close the window and emit the search result as flagged
    task automatic predict_match(input sample_pair_t p);
        logic [DIFF_BITS-1:0] mag_v;
        logic [SAMPLE_BITS-1:0] d_mag;
        longint unsigned mag;
        longint unsigned divisor;
        longint unsigned quot;
        longint unsigned cost;
        match_t m;
        d_mag = (p.ref_sample >= p.cand_sample) ? p.ref_sample - p.cand_sample
                                                : p.cand_sample - p.ref_sample;
        diff_acc   = diff_acc + DIFF_BITS'(p.ref_sample) - DIFF_BITS'(p.cand_sample);
        square_acc = square_acc + SQ_BITS'(32'(d_mag) * 32'(d_mag));
        if (p.window_end)
        begin
            divisor = (window_len == 0) ? 1 : window_len;
            mag_v = diff_acc[DIFF_BITS-1] ? DIFF_BITS'(0 - diff_acc) : diff_acc;
            mag = mag_v;
            quot = (mag * mag) / divisor;
            if (square_acc <= quot)
                cost = 0;
            else if (square_acc - quot > COST_MAX)
                cost = COST_MAX;
            else
                cost = square_acc - quot;
            if (!have_lowest || cost < lowest_cost)
            begin
                lowest_cost = SQ_BITS'(cost);
                lowest_dx = p.dx;
                lowest_dy = p.dy;
                have_lowest = 1'b1;
            end
            diff_acc = '0;
            square_acc = '0;
        end
        if (p.search_end)
        begin
            if (have_lowest)
            begin
                m.best_dx = lowest_dx;
                m.best_dy = lowest_dy;
                m.min_cost = lowest_cost[COST_BITS-1:0];
                m.found = 1'b1;
            end
            else
            begin
                m.best_dx = '0;
                m.best_dy = '0;
                m.min_cost = COST_MAX;
                m.found = 1'b0;
            end
            expected_matches.push_back(m);
            diff_acc = '0;
            square_acc = '0;
            lowest_cost = '0;
            lowest_dx = '0;
            lowest_dy = '0;
            have_lowest = 1'b0;
        end
    endtask

    task automatic push_sample(input logic [SAMPLE_BITS-1:0] a, input logic [SAMPLE_BITS-1:0] b,
                               input logic signed [COORD_BITS-1:0] dx,
                               input logic signed [COORD_BITS-1:0] dy,
                               input logic wend, input logic send);
        sample_pair_t p;
        p.ref_sample = a;
        p.cand_sample = b;
        p.dx = dx;
        p.dy = dy;
        p.window_end = wend;
        p.search_end = send;
        pending_pairs.push_back(p);
        queued_items++;
    endtask

    // One search: n_cand windows of about win_len pairs, sometimes ties and a cut-off tail
    task automatic queue_search(input int n_cand, input int win_len);
        logic [SAMPLE_BITS-1:0] ref_vals[$];
        logic [SAMPLE_BITS-1:0] cand_vals[$];
        logic [SAMPLE_BITS-1:0] a;
        logic [SAMPLE_BITS-1:0] b;
        logic signed [COORD_BITS-1:0] dx;
        logic signed [COORD_BITS-1:0] dy;
        int len;
        int mode;
        int offset;
        int tail;
        bit tie;
        if (n_cand == 0)
            tail = $urandom_range(1, 3);
        else
            tail = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
        for (int c = 0; c < n_cand; c++)
        begin
            dx = COORD_BITS'($urandom_range(0, 4095));
            dy = COORD_BITS'($urandom_range(0, 4095));
            tie = (c > 0) && ($urandom_range(0, 4) == 0);
            if (!tie)
            begin
                ref_vals.delete();
                cand_vals.delete();
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2 * win_len) : win_len;
                mode = $urandom_range(0, 3);
                offset = $urandom_range(0, 20);
                for (int s = 0; s < len; s++)
                begin
                    a = SAMPLE_BITS'($urandom_range(0, 255));
                    case (mode)
                        0: b = SAMPLE_BITS'($urandom_range(0, 255));
                        1: b = a + SAMPLE_BITS'($urandom_range(0, 6)) - SAMPLE_BITS'(3);
                        2: b = a + SAMPLE_BITS'(offset);
                        default:
                        begin
                            a = $urandom_range(0, 1) ? '1 : '0;
                            b = $urandom_range(0, 1) ? '1 : '0;
                        end
                    endcase
                    ref_vals.push_back(a);
                    cand_vals.push_back(b);
                end
            end
            for (int s = 0; s < ref_vals.size(); s++)
                push_sample(ref_vals[s], cand_vals[s], dx, dy, s == ref_vals.size() - 1,
                            (s == ref_vals.size() - 1) && (c == n_cand - 1) && (tail == 0));
        end
        // partial window cut by the search end
        for (int s = 0; s < tail; s++)
            push_sample(SAMPLE_BITS'($urandom_range(0, 255)), SAMPLE_BITS'($urandom_range(0, 255)),
                        COORD_BITS'($urandom_range(0, 4095)),
                        COORD_BITS'($urandom_range(0, 4095)), 1'b0, s == tail - 1);
        queued_searches++;
    endtask

    task automatic wait_idle();
        while (pending_pairs.size() != 0 || samples_bus.valid || expected_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window_len(input logic [WIN_BITS-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        window_len = value;
        @(negedge clk);
    endtask

    // Sample driver: pops pending pairs, inserts idle bursts
    int send_gap;
    int send_calm;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_bus.valid <= 1'b0;
            samples_bus.ref_sample <= '0;
            samples_bus.cand_sample <= '0;
            samples_bus.cand_dx <= '0;
            samples_bus.cand_dy <= '0;
            samples_bus.window_end <= 1'b0;
            samples_bus.search_end <= 1'b0;
            send_gap = 0;
            send_calm = 0;
        end
        else
        begin
            if (samples_bus.valid && samples_bus.ready)
                predict_match(on_bus);
            if (!samples_bus.valid || samples_bus.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    samples_bus.valid <= 1'b0;
                end
                else if (pending_pairs.size() == 0)
                    samples_bus.valid <= 1'b0;
                else if (idle_enable && send_calm == 0 && $urandom_range(0, 9) == 0)
                begin
                    send_gap = $urandom_range(0, 11);
                    samples_bus.valid <= 1'b0;
                end
                else
                begin
                    on_bus = pending_pairs.pop_front();
                    samples_bus.ref_sample <= on_bus.ref_sample;
                    samples_bus.cand_sample <= on_bus.cand_sample;
                    samples_bus.cand_dx <= on_bus.dx;
                    samples_bus.cand_dy <= on_bus.dy;
                    samples_bus.window_end <= on_bus.window_end;
                    samples_bus.search_end <= on_bus.search_end;
                    samples_bus.valid <= 1'b1;
                end
            end
            // stretches with no idling
            if (send_calm > 0)
                send_calm--;
            else if ($urandom_range(0, 199) == 0)
                send_calm = $urandom_range(30, 120);
        end
    end

    // Result ready: random stalls, one long hold-off on request
    int recv_stall;
    int recv_calm;
    int hold_left;
    bit hold_taken;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_bus.ready <= 1'b0;
            recv_stall = 0;
            recv_calm = 0;
            hold_left = 0;
            hold_taken = 1'b0;
        end
        else
        begin
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
                results_bus.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                results_bus.ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                results_bus.ready <= 1'b0;
            end
            else if (idle_enable && recv_calm == 0 && $urandom_range(0, 5) == 0)
            begin
                recv_stall = $urandom_range(0, 11);
                results_bus.ready <= 1'b0;
            end
            else
                results_bus.ready <= 1'b1;
            if (recv_calm > 0)
                recv_calm--;
            else if ($urandom_range(0, 149) == 0)
                recv_calm = $urandom_range(20, 80);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && results_bus.valid && results_bus.ready)
        begin
            if (expected_matches.size() == 0)
                report_mismatch("unexpected result, cost", results_bus.min_cost, 0);
            else
            begin
                match_t m;
                m = expected_matches.pop_front();
                if (results_bus.best_dx !== m.best_dx)
                    report_mismatch("best_dx", results_bus.best_dx, m.best_dx);
                if (results_bus.best_dy !== m.best_dy)
                    report_mismatch("best_dy", results_bus.best_dy, m.best_dy);
                if (results_bus.min_cost !== m.min_cost)
                    report_mismatch("min_cost", results_bus.min_cost, m.min_cost);
                if (results_bus.found !== m.found)
                    report_mismatch("found", results_bus.found, m.found);
            end
        end
    end

    // Watchdog on cycles with no item accepted on either side
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && !(samples_bus.valid && samples_bus.ready)
                      && !(results_bus.valid && results_bus.ready))
                quiet_cycles++;
            else
                quiet_cycles = 0;
        end
        $display("zssd_block_match_argmin_top test failed");
        $finish;
    end

    initial
    begin : sequencer
        int base_items;
        int base_searches;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        idle_enable = 1'b1;
        hold_req = 1'b0;
        error_count = 0;
        queued_items = 0;
        queued_searches = 0;
        window_len = WIN_RESET;
        diff_acc = '0;
        square_acc = '0;
        lowest_cost = '0;
        lowest_dx = '0;
        lowest_dy = '0;
        have_lowest = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed cases at the reset window length
        // search with no completed window
        push_sample(0, 0, 0, 0, 1'b0, 1'b1);
        // search end inside the first window
        push_sample(255, 0, 100, 100, 1'b0, 1'b0);
        push_sample(10, 3, 100, 100, 1'b0, 1'b1);
        // extreme samples; displacement taken from the closing pair
        push_sample(255, 0, 5, 5, 1'b0, 1'b0);
        push_sample(0, 255, 1, 1, 1'b0, 1'b0);
        push_sample(255, 255, -2048, 2047, 1'b1, 1'b0);
        // equal cost: the earlier candidate stays
        push_sample(255, 0, 9, 9, 1'b0, 1'b0);
        push_sample(0, 255, 9, 9, 1'b0, 1'b0);
        push_sample(0, 0, 2047, -2048, 1'b1, 1'b0);
        // zero cost takes over, then a higher cost is ignored
        push_sample(12, 12, -1, 0, 1'b1, 1'b0);
        push_sample(0, 255, 3, -3, 1'b1, 1'b0);
        // trailing partial window dropped at search end
        push_sample(200, 1, 7, 7, 1'b0, 1'b1);
        // window end and search end on the same pair
        push_sample(0, 255, -2048, -2048, 1'b1, 1'b1);
        queue_search(2, 25);
        wait_idle();

        // Length 1: longer windows give negative costs that clamp
        write_window_len(1);
        for (int i = 0; i < 6; i++)
            queue_search($urandom_range(0, 4), $urandom_range(1, 3));
        wait_idle();

        // Length 0 divides as 1
        write_window_len(0);
        for (int i = 0; i < 4; i++)
            queue_search($urandom_range(1, 3), $urandom_range(1, 2));
        wait_idle();

        // Window length 256; an overlong window of balanced signs saturates the cost
        write_window_len(256);
        for (int i = 0; i < 259; i++)
            push_sample(SAMPLE_BITS'((i % 2) ? 0 : 255), SAMPLE_BITS'((i % 2) ? 255 : 0),
                        11, -11, i == 258, i == 258);
        queue_search(2, 4);
        wait_idle();

        // Main random part over several small window lengths; one long result hold-off
        base_items = queued_items;
        base_searches = queued_searches;
        while (queued_items - base_items < RANDOM_ITEMS
               || queued_searches - base_searches < RANDOM_SEARCHES)
        begin
            write_window_len(WIN_BITS'($urandom_range(2, 8)));
            for (int i = 0; i < 8; i++)
                queue_search($urandom_range(0, 4), window_len == 0 ? 1 : window_len);
            hold_req = 1'b1;
            wait_idle();
        end

        // Top register value, no idling
        idle_enable = 1'b0;
        write_window_len(511);
        push_sample(3, 3, 21, 21, 1'b0, 1'b0);
        push_sample(3, 4, 21, 22, 1'b1, 1'b1);
        for (int i = 0; i < 4; i++)
            queue_search($urandom_range(1, 3), $urandom_range(1, 6));
        wait_idle();

        if (error_count == 0)
            $display("zssd_block_match_argmin_top test passed");
        else
            $display("zssd_block_match_argmin_top test failed");
        $finish;
    end

endmodule
